>>> hw/rtl/acl_pkg.sv
// package for the adaptive cascade lowpass: widths, register indexes, helpers
// no dependencies
`default_nettype none
package acl_pkg;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int STATE_BITS_DEF  = 32;
    localparam int REG_BITS        = 17;
    localparam int UNITY           = 65536;
    localparam int NUM_STAGES      = 4;

    typedef enum logic [1:0] {
        REG_BASE_AMOUNT = 2'd0,
        REG_TIGHTNESS   = 2'd1,
        REG_STAGE_CTRL  = 2'd2,
        REG_MIX         = 2'd3
    } t_reg_idx;

    // per-item settings shared by both lanes
    typedef struct packed {
        logic signed [17:0] t;      // tightness after halving, -32768..65536
        logic        [16:0] amt;    // 1..65536
        logic [3:0][16:0]   w;      // stage weights, Q16
        logic        [16:0] mix;    // Q16
    } t_coef;

    // lane status toward the top
    typedef struct packed {
        logic busy;
        logic done;
    } t_lane_stat;

    function automatic logic [16:0] sat_reg(input logic [16:0] v);
        sat_reg = (v > 17'(UNITY)) ? 17'(UNITY) : v;
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/acl_stream_if.sv
// valid/ready channel carrying one stereo pair and an end marker
// depends on nothing
`default_nettype none
interface acl_stream_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          frame_end;

    modport source (output valid, output left, output right, output frame_end,
                    input ready);
    modport sink (input valid, input left, input right, input frame_end,
                  output ready);
endinterface
`default_nettype wire

>>> hw/rtl/acl_lane.sv
// one channel lane: level coefficient, four state stages, dry/wet blend
// depends on acl_pkg; state of its channel lives here for both banks
`default_nettype none
module acl_lane #(
    parameter int SAMPLE_BITS = acl_pkg::SAMPLE_BITS_DEF,
    parameter int STATE_BITS  = acl_pkg::STATE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_bank,
    input  wire acl_pkg::t_coef                i_coef,
    input  wire logic signed [SAMPLE_BITS-1:0] i_x,
    output acl_pkg::t_lane_stat                o_stat,
    output logic signed [SAMPLE_BITS-1:0]      o_y
);
    localparam int FRAC = STATE_BITS - SAMPLE_BITS;
    localparam int DW   = STATE_BITS + 2;   // difference width
    localparam int PW   = DW + 33;          // product width
    localparam logic signed [19:0] UNITY_C = 20'(acl_pkg::UNITY);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_OFF  = 7'b0000010,
        S_K    = 7'b0000100,
        S_SD   = 7'b0001000,
        S_SY   = 7'b0010000,
        S_SB   = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state r_st, n_st;
    logic [1:0] r_stg, n_stg;
    logic signed [STATE_BITS-1:0] r_y [8];  // bank*4 + stage
    logic signed [STATE_BITS+1:0] r_cur, n_cur, r_xs;
    logic signed [STATE_BITS+1:0] r_ynew;
    logic [16:0] r_off;
    logic [32:0] r_k;
    logic [SAMPLE_BITS-1:0] r_ax;
    logic signed [SAMPLE_BITS-1:0] r_out;
    logic signed [SAMPLE_BITS-1:0] n_out;

    // shared multiplier: signed difference times unsigned Q32 coefficient
    logic signed [DW-1:0] m_d;
    logic [32:0] m_c;
    logic [DW-1:0] m_mag;
    logic [PW-1:0] m_prod;
    logic signed [DW-1:0] m_res;
    logic [2:0] yidx;
    logic signed [STATE_BITS+1:0] yold;

    assign yidx = {i_bank, r_stg};
    assign yold = (STATE_BITS+2)'(r_y[yidx]);

    always_comb begin
        m_d = '0;
        m_c = '0;
        case (r_st)
            S_SD: begin
                m_d = DW'(r_cur - yold);
                m_c = r_k;
            end
            S_SY: begin
                m_d = DW'(r_ynew - r_cur);
                m_c = {i_coef.w[r_stg], 16'd0};
            end
            S_FIN: begin
                m_d = DW'(r_cur - r_xs);
                m_c = {i_coef.mix, 16'd0};
            end
            default: ;
        endcase
        m_mag  = m_d[DW-1] ? DW'(-m_d) : DW'(m_d);
        m_prod = PW'(m_mag) * PW'(m_c);
        m_res  = m_d[DW-1] ? -DW'(m_prod >> 32) : DW'(m_prod >> 32);
    end

    // level offset, Q16, clamped
    logic signed [SAMPLE_BITS+19:0] off_prod;
    logic signed [19:0] off_raw;
    always_comb begin
        if (i_coef.t > 0) begin
            off_prod = (SAMPLE_BITS+20)'(r_ax) * (SAMPLE_BITS+20)'(i_coef.t);
            off_raw  = 20'(UNITY_C - i_coef.t) + 20'(off_prod >>> (SAMPLE_BITS-1));
        end else begin
            off_prod = (SAMPLE_BITS+20)'((SAMPLE_BITS+1)'(1) << (SAMPLE_BITS-1))
                       - (SAMPLE_BITS+20)'(r_ax);
            off_prod = off_prod * (SAMPLE_BITS+20)'(-i_coef.t);
            off_raw  = 20'(UNITY_C + i_coef.t) - 20'(off_prod >>> (SAMPLE_BITS-1));
        end
    end

    // final rounding: floor by FRAC bits and saturate
    logic signed [STATE_BITS+1:0] fin;
    logic signed [STATE_BITS+1-FRAC:0] fsh;
    always_comb begin
        fin = r_xs + (STATE_BITS+2)'(m_res);
        fsh = (STATE_BITS+2-FRAC)'(fin >>> FRAC);
        if (fsh < -(STATE_BITS+2-FRAC)'(1 << (SAMPLE_BITS-1)))
            n_out = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else if (fsh > (STATE_BITS+2-FRAC)'((1 << (SAMPLE_BITS-1)) - 1))
            n_out = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else
            n_out = SAMPLE_BITS'(fsh);
    end

    // sequencer
    always_comb begin
        n_st  = r_st;
        n_stg = r_stg;
        n_cur = r_cur;
        case (r_st)
            S_IDLE: begin
                if (i_start) begin
                    n_st  = S_OFF;
                    n_cur = (STATE_BITS+2)'(i_x) <<< FRAC;
                end
            end
            S_OFF:  n_st = S_K;
            S_K: begin
                n_stg = '0;
                n_st  = S_SB;
            end
            S_SB: n_st = (i_coef.w[r_stg] == '0) ? S_SY : S_SD;
            S_SD: n_st = S_SY;
            S_SY: begin
                if (i_coef.w[r_stg] != '0) n_cur = r_cur + (STATE_BITS+2)'(m_res);
                if (r_stg == 2'd3) n_st = S_FIN;
                else begin
                    n_stg = r_stg + 2'd1;
                    n_st  = S_SB;
                end
            end
            S_FIN: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_stg <= '0;
            for (int i = 0; i < 8; i++) r_y[i] <= '0;
        end else begin
            r_st  <= n_st;
            r_stg <= n_stg;
            if (r_st == S_SD) begin
                r_ynew <= yold + (STATE_BITS+2)'(m_res);
                r_y[yidx] <= STATE_BITS'(yold + (STATE_BITS+2)'(m_res));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        case (r_st)
            S_IDLE: if (i_start) begin
                r_ax  <= i_x[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_x) : SAMPLE_BITS'(i_x);
                r_xs  <= (STATE_BITS+2)'(i_x) <<< FRAC;
            end
            S_OFF: r_off <= (off_raw < 20'sd1) ? 17'd1 :
                            (off_raw > UNITY_C) ? 17'(acl_pkg::UNITY) : 17'(off_raw);
            S_K:   r_k <= 33'(r_off) * 33'(i_coef.amt);
            S_FIN: r_out <= n_out;
            default: ;
        endcase
    end

    assign o_stat.busy = (r_st != S_IDLE);
    assign o_stat.done = (r_st == S_FIN);
    assign o_y = r_out;

    // the done pulse only follows a blend step
    a_fin_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_FIN) |-> $past(r_st == S_SY)) else $error("fin out of order");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OFF) |-> $past(r_st == S_IDLE)) else $error("start not from idle");
    a_stage_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_K) |=> (r_stg == 2'd0)) else $error("stage count not cleared");
endmodule
`default_nettype wire

>>> hw/rtl/adaptive_cascade_lowpass.sv
// top level of the adaptive cascade lowpass: config registers, two lanes, output merge
// depends on acl_pkg, acl_stream_if and acl_lane
`default_nettype none
// Usage: stereo pairs enter on i_in (valid/ready), filtered pairs leave on o_out.
// One item is taken at a time. From transfer to a valid result, the lane sequencer
// steps through offset, coefficient, then a state and a blend multiply per active
// stage on one shared multiplier (a bypassed stage skips its state step), a final
// mix multiply and the merge. Input is ready again from the cycle in which the
// result becomes valid, so a new pair is not taken before the last one is through.
// Both channels run in their own lane at once, and the merge stage joins their
// results.
// A result waits in the output register while the receiver stalls; the next pair
// is accepted then and its computation runs, but its result is held back until the
// register frees, and input stays blocked meanwhile. Configuration writes on
// i_cfg_we/i_cfg_idx/i_cfg_data belong in idle time; settings are latched at each
// input transfer. Reset (synchronous, active low) restores register defaults,
// clears all filter state and the bank select, and empties the output.
module adaptive_cascade_lowpass #(
    parameter int SAMPLE_BITS = acl_pkg::SAMPLE_BITS_DEF,
    parameter int STATE_BITS  = acl_pkg::STATE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [16:0]        i_cfg_data,
    acl_stream_if.sink              i_in,
    acl_stream_if.source            o_out
);
    logic [16:0] r_base, r_tight, r_stage, r_mix;
    logic r_bank, r_busy, r_pend;
    logic signed [SAMPLE_BITS-1:0] r_lx, r_rx;
    logic r_fe, r_fe_pend, r_ovalid;
    logic signed [SAMPLE_BITS-1:0] r_lo, r_ro;
    logic r_feo;
    acl_pkg::t_coef r_coef, n_coef;
    acl_pkg::t_lane_stat st_l, st_r;
    logic signed [SAMPLE_BITS-1:0] y_l, y_r;
    logic start, accept;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= 17'd32768;
            r_tight <= 17'd32768;
            r_stage <= 17'd65536;
            r_mix   <= 17'd65536;
        end else if (i_cfg_we) begin
            case (acl_pkg::t_reg_idx'(i_cfg_idx))
                acl_pkg::REG_BASE_AMOUNT: r_base  <= i_cfg_data;
                acl_pkg::REG_TIGHTNESS:   r_tight <= i_cfg_data;
                acl_pkg::REG_STAGE_CTRL:  r_stage <= i_cfg_data;
                acl_pkg::REG_MIX:         r_mix   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-item coefficients derived from the registers
    logic signed [18:0] t_raw, amt_raw;
    logic [18:0] c4;
    always_comb begin
        t_raw   = 19'sd2 * $signed({2'b0, acl_pkg::sat_reg(r_tight)}) - 19'sd65536;
        amt_raw = $signed({2'b0, acl_pkg::sat_reg(r_base)})
                  + ((t_raw < 0) ? -t_raw : t_raw);
        c4      = {acl_pkg::sat_reg(r_stage), 2'b00};
        n_coef.amt = (amt_raw < 19'sd1) ? 17'd1 :
                     (amt_raw > 19'sd65536) ? 17'd65536 : amt_raw[16:0];
        n_coef.t   = (t_raw < 0) ? 18'(-((-t_raw) >>> 1)) : 18'(t_raw);
        n_coef.mix = acl_pkg::sat_reg(r_mix);
        n_coef.w   = {17'd0, 17'd65536, 17'd65536, 17'd65536};
        if (c4 < 19'd65536) begin
            n_coef.w = {17'd0, 17'd0, 17'd0, c4[16:0]};
        end else if (c4 < 19'd131072) begin
            n_coef.w = {17'd0, 17'd0, 17'(c4 - 19'd65536), 17'd65536};
        end else if (c4 < 19'd196608) begin
            n_coef.w = {17'd0, 17'(c4 - 19'd131072), 17'd65536, 17'd65536};
        end else begin
            n_coef.w[3] = 17'(c4 - 19'd196608);
        end
    end

    assign i_in.ready = !r_busy && !r_pend;
    assign accept = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lx   <= i_in.left;
            r_rx   <= i_in.right;
            r_fe   <= i_in.frame_end;
            r_coef <= n_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) start <= 1'b0;
        else start <= accept;
    end

    acl_lane #(.SAMPLE_BITS(SAMPLE_BITS), .STATE_BITS(STATE_BITS)) u_left (
        .i_clk, .i_rst_n, .i_start(start), .i_bank(r_bank), .i_coef(r_coef),
        .i_x(r_lx), .o_stat(st_l), .o_y(y_l));
    acl_lane #(.SAMPLE_BITS(SAMPLE_BITS), .STATE_BITS(STATE_BITS)) u_right (
        .i_clk, .i_rst_n, .i_start(start), .i_bank(r_bank), .i_coef(r_coef),
        .i_x(r_rx), .o_stat(st_r), .o_y(y_r));

    // merge: lane results land in the cycle after done; held pending while output full and stalled
    logic r_land;
    logic fire;
    assign fire = (r_pend || r_land) && (!r_ovalid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pend   <= 1'b0;
            r_land   <= 1'b0;
            r_ovalid <= 1'b0;
            r_bank   <= 1'b0;
        end else begin
            r_land <= st_l.done;
            if (accept) r_busy <= 1'b1;
            else if (r_land) r_busy <= 1'b0;
            if (r_land) begin
                r_bank    <= ~r_bank;
                r_fe_pend <= r_fe;
            end
            if (fire) r_pend <= 1'b0;
            else if (r_land) r_pend <= 1'b1;
            if (fire) begin
                r_ovalid <= 1'b1;
                r_lo <= y_l;
                r_ro <= y_r;
                r_feo <= r_land ? r_fe : r_fe_pend;
            end else if (o_out.valid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.left      = r_lo;
    assign o_out.right     = r_ro;
    assign o_out.frame_end = r_feo;

    a_lanes_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_l.done == st_r.done) else $error("lanes out of step");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_l.busy |-> !i_in.ready) else $error("accept while busy");
    a_bank_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_land |=> (r_bank != $past(r_bank))) else $error("bank did not toggle");
endmodule
`default_nettype wire

>>> dv/adaptive_cascade_lowpass_tb.sv
// testbench for the adaptive cascade lowpass: directed and random stereo pairs,
// register sweeps and output back-pressure, checked against an in-bench model
// depends on acl_pkg, acl_stream_if and adaptive_cascade_lowpass
`default_nettype none
module adaptive_cascade_lowpass_tb;
    localparam int  SB = 24;
    localparam int  FRAC = 8;
    localparam longint ONE_Q16 = 65536;
    localparam longint SAMPLE_ONE = longint'(1) << (SB - 1);
    localparam longint STATE_HALF = longint'(1) << 31;
    localparam int  CYCLE_LIMIT = 1000000;

    typedef struct {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
        logic                 fe;
    } t_pair;

    // filter model plus queue of expected output pairs
    class lowpass_scoreboard;
        longint regs[4];
        longint store[16];
        bit     bank;
        t_pair  pending[$];
        int     errors;
        int     matched;

        function void clear();
            regs[acl_pkg::REG_BASE_AMOUNT] = 32768;
            regs[acl_pkg::REG_TIGHTNESS]   = 32768;
            regs[acl_pkg::REG_STAGE_CTRL]  = 65536;
            regs[acl_pkg::REG_MIX]         = 65536;
            foreach (store[i]) store[i] = 0;
            bank = 0;
            errors = 0;
            matched = 0;
        endfunction

        function void write_reg(acl_pkg::t_reg_idx idx, logic [16:0] val);
            regs[idx] = val;
        endfunction

        function longint clip_reg(longint v);
            return v > ONE_Q16 ? ONE_Q16 : v;
        endfunction

        // a*k/2^32 rounded toward zero
        function longint mul_q32(longint a, longint unsigned k);
            longint unsigned mag, r;
            mag = a < 0 ? longint'(-a) : a;
            r = (mag >> 32) * k + (((mag & 64'hFFFF_FFFF) * k) >> 32);
            return a < 0 ? -longint'(r) : longint'(r);
        endfunction

        function longint level_gain(longint x, longint t);
            longint ax, off;
            ax = x < 0 ? -x : x;
            if (t > 0) off = (ONE_Q16 - t) + ((ax * t) >>> (SB - 1));
            else off = ONE_Q16 + t - (((SAMPLE_ONE - ax) * (-t)) >>> (SB - 1));
            if (off < 1) off = 1;
            if (off > ONE_Q16) off = ONE_Q16;
            return off;
        endfunction

        function void note_input(t_pair p);
            longint t, amt, c4, x, xs, cur, y, fin, res;
            longint w[4];
            longint unsigned k, wet, u;
            t_pair o;
            t = 2 * clip_reg(regs[acl_pkg::REG_TIGHTNESS]) - ONE_Q16;
            amt = clip_reg(regs[acl_pkg::REG_BASE_AMOUNT]) + (t < 0 ? -t : t);
            c4 = 4 * clip_reg(regs[acl_pkg::REG_STAGE_CTRL]);
            wet = longint'(clip_reg(regs[acl_pkg::REG_MIX])) << 16;
            if (amt < 1) amt = 1;
            if (amt > ONE_Q16) amt = ONE_Q16;
            if (t < 0) t = -((-t) >>> 1);
            // progressive stage weights
            w = '{ONE_Q16, ONE_Q16, ONE_Q16, 0};
            if (c4 < ONE_Q16) begin
                w[0] = c4; w[1] = 0; w[2] = 0;
            end else if (c4 < 2 * ONE_Q16) begin
                w[1] = c4 - ONE_Q16; w[2] = 0;
            end else if (c4 < 3 * ONE_Q16) begin
                w[2] = c4 - 2 * ONE_Q16;
            end else begin
                w[3] = c4 - 3 * ONE_Q16;
            end
            for (int ch = 0; ch < 2; ch++) begin
                x = ch == 0 ? longint'(p.left) : longint'(p.right);
                xs = x * 256;
                k = longint'(level_gain(x, t)) * longint'(amt);
                cur = xs;
                for (int s = 0; s < 4; s++) begin
                    int idx;
                    if (w[s] == 0) continue;
                    idx = bank * 8 + s * 2 + ch;
                    y = store[idx];
                    y += mul_q32(cur - y, k);
                    store[idx] = y;
                    cur += mul_q32(y - cur, longint'(w[s]) << 16);
                end
                fin = xs + mul_q32(cur - xs, wet);
                if (fin < -STATE_HALF) fin = -STATE_HALF;
                if (fin > STATE_HALF - 1) fin = STATE_HALF - 1;
                u = longint'(fin + STATE_HALF) >> FRAC;
                res = longint'(u) - SAMPLE_ONE;
                if (res < -SAMPLE_ONE) res = -SAMPLE_ONE;
                if (res > SAMPLE_ONE - 1) res = SAMPLE_ONE - 1;
                if (ch == 0) o.left = res[SB-1:0];
                else o.right = res[SB-1:0];
            end
            o.fe = p.fe;
            bank = ~bank;
            pending.push_back(o);
        endfunction

        task report(string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        task check_result(t_pair got);
            t_pair e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected pair %0d %0d", got.left, got.right));
                return;
            end
            e = pending.pop_front();
            if (got.left !== e.left)
                report($sformatf("left got %0d want %0d", got.left, e.left));
            if (got.right !== e.right)
                report($sformatf("right got %0d want %0d", got.right, e.right));
            if (got.fe !== e.fe)
                report($sformatf("frame end got %0b want %0b", got.fe, e.fe));
            matched++;
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_idx = '0;
    logic [16:0] cfg_data = '0;
    int          cycles = 0;
    int          hold_cycles = 0;
    bit          no_idle = 0;
    lowpass_scoreboard sb;

    acl_stream_if #(.SAMPLE_BITS(SB)) in_ch ();
    acl_stream_if #(.SAMPLE_BITS(SB)) out_ch ();

    adaptive_cascade_lowpass dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("adaptive_cascade_lowpass test failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver: random stalls, plus a long hold-off when requested
    initial begin
        out_ch.ready = 0;
        forever begin
            int g;
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                out_ch.ready = 0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
            end
            g = gap_len();
            if (g > 0) begin
                out_ch.ready = 0;
                repeat (g - 1) @(negedge i_clk);
            end else begin
                out_ch.ready = 1;
            end
        end
    end

    // output transfer check
    always @(posedge i_clk) begin
        t_pair got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.left = out_ch.left;
            got.right = out_ch.right;
            got.fe = out_ch.frame_end;
            sb.check_result(got);
        end
    end

    task send_pair(logic signed [SB-1:0] l, logic signed [SB-1:0] r, logic fe);
        t_pair p;
        int g;
        @(negedge i_clk);
        in_ch.valid = 1;
        in_ch.left = l;
        in_ch.right = r;
        in_ch.frame_end = fe;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        p.left = l;
        p.right = r;
        p.fe = fe;
        sb.note_input(p);
        g = gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            in_ch.valid = 0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    // quiet point: every result back, then latency margin
    task drain();
        @(negedge i_clk);
        in_ch.valid = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task write_reg(acl_pkg::t_reg_idx idx, logic [16:0] val);
        @(negedge i_clk);
        cfg_we = 1;
        cfg_idx = idx;
        cfg_data = val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        cfg_we = 0;
    endtask

    function automatic logic signed [SB-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(SB-1){1'b1}}};
            1: return {1'b1, {(SB-1){1'b0}}};
            2: return SB'($signed($urandom_range(0, 511)) - 256);
            default: return SB'($urandom());
        endcase
    endfunction

    initial begin
        logic [16:0] settings[8][4];
        sb = new();
        sb.clear();
        in_ch.valid = 0;
        in_ch.left = '0;
        in_ch.right = '0;
        in_ch.frame_end = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: extremes, zero, sign edges, end marker, at reset settings
        send_pair(24'sh7FFFFF, 24'sh800000, 1);
        send_pair(24'sh800000, 24'sh7FFFFF, 0);
        send_pair(0, 0, 1);
        send_pair(-1, 1, 0);
        send_pair(24'sh7FFFFF, 24'sh7FFFFF, 0);
        send_pair(24'sh800000, 24'sh800000, 1);
        send_pair(24'sh555555, 24'shAAAAAA, 0);
        send_pair(24'shAAAAAA, 24'sh555555, 1);
        drain();

        // register sets: base, tightness, stages, mix; extremes and over-range
        settings[0] = '{17'd0, 17'd0, 17'd0, 17'd0};
        settings[1] = '{17'd65536, 17'd65536, 17'd10000, 17'd65536};
        settings[2] = '{17'd131071, 17'd131071, 17'd30000, 17'd32768};
        settings[3] = '{17'd1, 17'd32768, 17'd45000, 17'd131071};
        settings[4] = '{17'd2000, 17'd0, 17'd60000, 17'd50000};
        settings[5] = '{17'd40000, 17'd10000, 17'd131071, 17'd65536};
        settings[6] = '{17'd0, 17'd32768, 17'd16384, 17'd1};
        settings[7] = '{17'd20000, 17'd50000, 17'd65536, 17'd65536};

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(acl_pkg::REG_BASE_AMOUNT, settings[ph][0]);
            write_reg(acl_pkg::REG_TIGHTNESS, settings[ph][1]);
            write_reg(acl_pkg::REG_STAGE_CTRL, settings[ph][2]);
            write_reg(acl_pkg::REG_MIX, settings[ph][3]);
            no_idle = (ph % 3 == 2);
            if (ph == 4) hold_cycles = 300;
            for (int n = 0; n < 125; n++)
                send_pair(rand_sample(), rand_sample(), 1'($urandom()));
            no_idle = 0;
            drain();
            // random register values after the last phase too
            if (ph == 7) begin
                write_reg(acl_pkg::REG_BASE_AMOUNT, 17'($urandom()));
                write_reg(acl_pkg::REG_TIGHTNESS, 17'($urandom()));
                write_reg(acl_pkg::REG_STAGE_CTRL, 17'($urandom()));
                write_reg(acl_pkg::REG_MIX, 17'($urandom()));
                for (int n = 0; n < 40; n++)
                    send_pair(rand_sample(), rand_sample(), 1'($urandom()));
                drain();
            end
        end

        $display("covered %0d filtered pairs over ten register sets, with stalls on both sides",
                 sb.matched);
        $display("including a long output hold-off; %0d mismatches", sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("adaptive_cascade_lowpass test passed");
        end else begin
            $display("adaptive_cascade_lowpass test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/acl_pkg.sv
hw/rtl/acl_stream_if.sv
hw/rtl/acl_lane.sv
hw/rtl/adaptive_cascade_lowpass.sv
dv/adaptive_cascade_lowpass_tb.sv
